// ===== hw/rtl/dsfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package dsfd_pkg;

   // framing symbols
   localparam logic [7:0] SymDle = 8'h10;
   localparam logic [7:0] SymStx = 8'h02;
   localparam logic [7:0] SymEtx = 8'h03;
   localparam logic [7:0] SymNak = 8'h15;

   // byte counter limits
   localparam logic [8:0] CountMax    = 9'd260;
   localparam logic [8:0] ShortLimit  = 9'd5;
   localparam logic [8:0] HeaderBytes = 9'd4;

   typedef enum logic [12:0] {
      PH_H0     = 13'b0_0000_0000_0001,
      PH_H1     = 13'b0_0000_0000_0010,
      PH_STATUS = 13'b0_0000_0000_0100,
      PH_LEN    = 13'b0_0000_0000_1000,
      PH_SKIP   = 13'b0_0000_0001_0000,
      PH_DATA   = 13'b0_0000_0010_0000,
      PH_ESC    = 13'b0_0000_0100_0000,
      PH_BCC    = 13'b0_0000_1000_0000,
      PH_BCC2   = 13'b0_0001_0000_0000,
      PH_END1   = 13'b0_0010_0000_0000,
      PH_END2   = 13'b0_0100_0000_0000,
      PH_DONE   = 13'b0_1000_0000_0000,
      PH_IGNORE = 13'b1_0000_0000_0000
   } phase_type;

   typedef enum logic [3:0] {
      ERR_OK         = 4'd0,
      ERR_NAK        = 4'd1,
      ERR_SHORT      = 4'd2,
      ERR_HEADER     = 4'd3,
      ERR_LENSHORT   = 4'd4,
      ERR_STUFF      = 4'd5,
      ERR_CHECK      = 4'd6,
      ERR_NOTDOUBLED = 4'd7,
      ERR_END        = 4'd8
   } err_type;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic       is_verdict;
      logic [7:0] data_byte;
      logic [7:0] reader_status;
      logic [3:0] error_code;
   } rsp_type;

   typedef struct packed {
      phase_type  phase;
      logic [8:0] byte_count;
      logic [7:0] frame_length;
      logic [7:0] data_left;
      logic [7:0] status_held;
      logic [7:0] check_acc;
      err_type    first_fault;
   } state_type;

   localparam state_type StateReset = '{
      phase:        PH_H0,
      byte_count:   9'd0,
      frame_length: 8'd0,
      data_left:    8'd0,
      status_held:  8'd0,
      check_acc:    8'd0,
      first_fault:  ERR_OK
   };

endpackage

`default_nettype wire

// ===== hw/rtl/dle_stx_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none

// dle stx frame decoder
// - req channel: one answer byte per item, end_of_buffer marks the buffer's last byte
// - rsp channel: an unstuffed data byte (is_verdict 0) or, for the last byte,
//   one verdict with the header status and an error code (is_verdict 1)
// - header and trailer bytes, the skipped length extra byte and bytes after
//   the frame or after a fault give no item on rsp
// - a result is registered and shows on rsp in the cycle after its req item is taken
// - throughput: one byte per cycle while rsp_ready holds; the parse state is updated by a single
//   combinational step between the request port and the result register
// - req_ready is high while the result register is empty or being drained, so a
//   byte is taken in the same cycle that the previous result leaves
// - when the receiver stalls, the result register holds its item and req_ready
//   falls until rsp_ready returns
// - reset (synchronous, active high) empties the result register and puts the
//   parser back to waiting for the first header byte; the last byte of each
//   buffer resets the parser the same way once its verdict is formed
module dle_stx_frame_decoder
   import dsfd_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire req_type req_data,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output rsp_type     rsp_data
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   rsp_type   rsp_data_ff;
   rsp_type   rsp_data_in;
   logic      req_take;
   logic      step_valid;
   rsp_type   step_result;
   state_type step_state;

   // parse step for the byte on the request port
   dsfd_step u_step (
      .cur_state    (state_ff),
      .req_item     (req_data),
      .next_state   (step_state),
      .result_valid (step_valid),
      .result       (step_result)
   );

   // room when the result register is empty or its item is leaving now
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (req_take) begin
         state_in = step_state;
         if (step_valid) begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = step_result;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StateReset;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/dsfd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one byte of parsing: next state and the result it causes
module dsfd_step
   import dsfd_pkg::*;
(
   input  wire state_type cur_state,
   input  wire req_type   req_item,
   output state_type      next_state,
   output logic           result_valid,
   output rsp_type        result
);

   logic       emit;
   logic [7:0] dbyte;
   logic [7:0] dec_left;
   err_type    verdict_err;
   state_type  parsed;

   always_comb begin
      parsed   = cur_state;
      emit     = 1'b0;
      dbyte    = 8'd0;
      dec_left = cur_state.data_left - 8'd1;

      if (cur_state.byte_count < CountMax) begin
         parsed.byte_count = cur_state.byte_count + 9'd1;
      end

      unique case (cur_state.phase)
         PH_H0: begin
            if (req_item.rx_byte == SymNak) begin
               parsed.status_held = SymNak;
               parsed.first_fault = ERR_NAK;
               parsed.phase       = PH_IGNORE;
            end else if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_H1;
            end else begin
               parsed.first_fault = ERR_HEADER;
               parsed.phase       = PH_IGNORE;
            end
         end
         PH_H1: begin
            if (req_item.rx_byte == SymStx) begin
               parsed.phase = PH_STATUS;
            end else begin
               parsed.first_fault = ERR_HEADER;
               parsed.phase       = PH_IGNORE;
            end
         end
         PH_STATUS: begin
            parsed.status_held = req_item.rx_byte;
            parsed.check_acc   = req_item.rx_byte;
            parsed.phase       = PH_LEN;
         end
         PH_LEN: begin
            parsed.frame_length = req_item.rx_byte;
            parsed.data_left    = req_item.rx_byte;
            parsed.check_acc    = cur_state.check_acc ^ req_item.rx_byte;
            if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_SKIP;
            end else if (req_item.rx_byte == 8'd0) begin
               parsed.phase = PH_BCC;
            end else begin
               parsed.phase = PH_DATA;
            end
         end
         PH_SKIP: begin
            parsed.phase = PH_DATA;
         end
         PH_DATA: begin
            if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_ESC;
            end else begin
               emit             = 1'b1;
               dbyte            = req_item.rx_byte;
               parsed.check_acc = cur_state.check_acc ^ req_item.rx_byte;
               parsed.data_left = dec_left;
               parsed.phase     = (dec_left == 8'd0) ? PH_BCC : PH_DATA;
            end
         end
         PH_ESC: begin
            if (req_item.rx_byte == SymDle) begin
               emit             = 1'b1;
               dbyte            = SymDle;
               parsed.check_acc = cur_state.check_acc ^ SymDle;
               parsed.data_left = dec_left;
               parsed.phase     = (dec_left == 8'd0) ? PH_BCC : PH_DATA;
            end else begin
               parsed.first_fault = ERR_STUFF;
               parsed.phase       = PH_IGNORE;
            end
         end
         PH_BCC: begin
            if (req_item.rx_byte != cur_state.check_acc) begin
               parsed.first_fault = ERR_CHECK;
               parsed.phase       = PH_IGNORE;
            end else if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_BCC2;
            end else begin
               parsed.phase = PH_END1;
            end
         end
         PH_BCC2: begin
            if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_END1;
            end else begin
               parsed.first_fault = ERR_NOTDOUBLED;
               parsed.phase       = PH_IGNORE;
            end
         end
         PH_END1: begin
            if (req_item.rx_byte == SymDle) begin
               parsed.phase = PH_END2;
            end else begin
               parsed.first_fault = ERR_END;
               parsed.phase       = PH_IGNORE;
            end
         end
         PH_END2: begin
            if (req_item.rx_byte == SymEtx) begin
               parsed.phase = PH_DONE;
            end else begin
               parsed.first_fault = ERR_END;
               parsed.phase       = PH_IGNORE;
            end
         end
         default: begin
            // done, ignore and meaningless codes: bytes are dropped
            parsed.phase = PH_IGNORE;
            if (cur_state.phase == PH_DONE) begin
               parsed.phase = PH_DONE;
            end
         end
      endcase

      // verdict ranking
      priority if (parsed.byte_count < ShortLimit) begin
         verdict_err = ERR_SHORT;
      end else if (parsed.first_fault == ERR_NAK) begin
         verdict_err = ERR_NAK;
      end else if (parsed.first_fault == ERR_HEADER) begin
         verdict_err = ERR_HEADER;
      end else if ((parsed.byte_count - HeaderBytes) < {1'b0, parsed.frame_length}) begin
         verdict_err = ERR_LENSHORT;
      end else if (parsed.first_fault != ERR_OK) begin
         verdict_err = parsed.first_fault;
      end else if (parsed.phase != PH_DONE) begin
         verdict_err = ERR_END;
      end else begin
         verdict_err = ERR_OK;
      end

      if (req_item.end_of_buffer) begin
         next_state           = StateReset;
         result_valid         = 1'b1;
         result.is_verdict    = 1'b1;
         result.data_byte     = 8'd0;
         result.reader_status = parsed.status_held;
         result.error_code    = verdict_err;
      end else begin
         next_state           = parsed;
         result_valid         = emit;
         result.is_verdict    = 1'b0;
         result.data_byte     = dbyte;
         result.reader_status = 8'd0;
         result.error_code    = ERR_OK;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/dsfd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module dsfd_checker
   import dsfd_pkg::*;
(
   input wire          clock,
   input wire          reset,
   input wire          req_valid,
   input wire          req_ready,
   input wire req_type req_data,
   input wire          rsp_valid,
   input wire          rsp_ready,
   input wire rsp_type rsp_data
);

   // a stalled result keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled rsp item changed");

   // the last byte of a buffer gives a verdict in the next cycle
   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_buffer
         |=> rsp_valid && rsp_data.is_verdict)
      else $error("no verdict after end of buffer");

   // data items carry no status or error
   a_data_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.is_verdict
         |-> rsp_data.reader_status == 8'd0 && rsp_data.error_code == ERR_OK)
      else $error("data item with status or error");

   // a nak verdict reports the nak status
   a_nak_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_verdict && rsp_data.error_code == ERR_NAK
         |-> rsp_data.reader_status == SymNak)
      else $error("nak verdict without nak status");

   // verdicts only use defined error codes
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_verdict |-> rsp_data.error_code <= ERR_END)
      else $error("undefined error code");

endmodule

bind dle_stx_frame_decoder dsfd_checker u_dsfd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

// ===== test/tb_dle_stx_frame_decoder.sv =====
`timescale 1ns / 1ps

module tb_dle_stx_frame_decoder;
   import dsfd_pkg::*;

   // run-away guard, far above the slowest legal run
   localparam int CycleLimit = 400000;
   // idling pattern changes every this many accepted items
   localparam int ModeSpan   = 200;

   typedef enum logic [1:0] {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_type;

   // how a generated answer buffer is built or damaged
   typedef enum logic [3:0] {
      BUF_GOOD,
      BUF_TRAILING,
      BUF_NAK,
      BUF_BAD_H0,
      BUF_BAD_H1,
      BUF_BAD_STUFF,
      BUF_BAD_CHECK,
      BUF_NOT_DOUBLED,
      BUF_BAD_END,
      BUF_TRUNC,
      BUF_NOISE
   } buf_type;

   logic    clock;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   dle_stx_frame_decoder uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   // bytes still to be offered, and the decoded items still awaited
   req_type  rx_bytes[$];
   rsp_type  frame_results[$];
   // item indices before which the sender waits for every result to drain
   int       drain_at[$];

   int       n_sent = 0;     // accepted bytes
   int       n_pred = 0;     // results predicted
   int       n_done = 0;     // results received and checked
   int       n_launched = 0; // bytes put on the request port
   int       n_fail = 0;
   int       cycles = 0;
   bit       holding;
   idle_type idle_mode;

   assign idle_mode = idle_type'((n_sent / ModeSpan) % 4);

   // decoder state, mirrored at the block's own widths
   phase_type  dec_phase;
   logic [8:0] dec_count;
   logic [7:0] dec_len;
   logic [7:0] dec_left;
   logic [7:0] dec_status;
   logic [7:0] dec_acc;
   err_type    dec_fault;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // decoder prediction
   // ------------------------------------------------------------------

   task automatic clear_decoder();
      dec_phase  = PH_H0;
      dec_count  = '0;
      dec_len    = '0;
      dec_left   = '0;
      dec_status = '0;
      dec_acc    = '0;
      dec_fault  = ERR_OK;
   endtask

   // latch a fault and ignore the rest of the buffer
   task automatic set_fault(input err_type code);
      dec_fault = code;
      dec_phase = PH_IGNORE;
   endtask

   // one payload byte consumed, move on to the check byte when none are left
   task automatic count_data();
      dec_left  = dec_left - 8'd1;
      dec_phase = (dec_left == 8'd0) ? PH_BCC : PH_DATA;
   endtask

   task automatic decode_byte(input req_type it);
      logic [7:0] b;
      logic       emit;
      logic [7:0] payload;
      err_type    verdict;
      rsp_type    r;
      b       = it.rx_byte;
      emit    = 1'b0;
      payload = '0;
      if (dec_count < CountMax) dec_count = dec_count + 9'd1;
      case (dec_phase)
         PH_H0: begin
            if (b == SymNak) begin
               dec_status = SymNak;
               set_fault(ERR_NAK);
            end else if (b == SymDle) begin
               dec_phase = PH_H1;
            end else begin
               set_fault(ERR_HEADER);
            end
         end
         PH_H1: begin
            if (b == SymStx) dec_phase = PH_STATUS;
            else set_fault(ERR_HEADER);
         end
         PH_STATUS: begin
            dec_status = b;
            dec_acc    = b;
            dec_phase  = PH_LEN;
         end
         PH_LEN: begin
            dec_len  = b;
            dec_left = b;
            dec_acc  = dec_acc ^ b;
            // a length equal to dle drags one unchecked extra byte along
            if (b == SymDle) dec_phase = PH_SKIP;
            else if (b == 8'd0) dec_phase = PH_BCC;
            else dec_phase = PH_DATA;
         end
         PH_SKIP: dec_phase = PH_DATA;
         PH_DATA: begin
            if (b == SymDle) begin
               dec_phase = PH_ESC;
            end else begin
               emit    = 1'b1;
               payload = b;
               dec_acc = dec_acc ^ b;
               count_data();
            end
         end
         PH_ESC: begin
            // only a doubled dle is legal inside the data
            if (b == SymDle) begin
               emit    = 1'b1;
               payload = SymDle;
               dec_acc = dec_acc ^ SymDle;
               count_data();
            end else begin
               set_fault(ERR_STUFF);
            end
         end
         PH_BCC: begin
            if (b != dec_acc) set_fault(ERR_CHECK);
            else if (b == SymDle) dec_phase = PH_BCC2;
            else dec_phase = PH_END1;
         end
         PH_BCC2: begin
            if (b == SymDle) dec_phase = PH_END1;
            else set_fault(ERR_NOTDOUBLED);
         end
         PH_END1: begin
            if (b == SymDle) dec_phase = PH_END2;
            else set_fault(ERR_END);
         end
         PH_END2: begin
            if (b == SymEtx) dec_phase = PH_DONE;
            else set_fault(ERR_END);
         end
         default: ;
      endcase

      if (it.end_of_buffer) begin
         // verdict ranking: too short, nak, bad header, length short, then
         // the first fault seen, then a frame that never reached dle etx
         if (dec_count < ShortLimit) verdict = ERR_SHORT;
         else if (dec_fault == ERR_NAK) verdict = ERR_NAK;
         else if (dec_fault == ERR_HEADER) verdict = ERR_HEADER;
         else if ((dec_count - HeaderBytes) < {1'b0, dec_len}) verdict = ERR_LENSHORT;
         else if (dec_fault != ERR_OK) verdict = dec_fault;
         else if (dec_phase != PH_DONE) verdict = ERR_END;
         else verdict = ERR_OK;
         r.is_verdict    = 1'b1;
         r.data_byte     = '0;
         r.reader_status = dec_status;
         r.error_code    = verdict;
         frame_results = {frame_results, r};
         n_pred <= n_pred + 1;
         clear_decoder();
      end else if (emit) begin
         r.is_verdict    = 1'b0;
         r.data_byte     = payload;
         r.reader_status = '0;
         r.error_code    = ERR_OK;
         frame_results = {frame_results, r};
         n_pred <= n_pred + 1;
      end
   endtask

   // ------------------------------------------------------------------
   // buffer generation
   // ------------------------------------------------------------------

   // random byte biased towards the framing symbols
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0: return SymDle;
         1: return SymStx;
         2: return SymEtx;
         3: return SymNak;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [7:0] not_dle();
      logic [7:0] b;
      b = 8'($urandom);
      if (b == SymDle) b = ~b;
      return b;
   endfunction

   function automatic bit roll(input int pct);
      return $urandom_range(0, 99) < pct;
   endfunction

   // queue one answer buffer, end_of_buffer on its last byte
   task automatic push_buffer(input logic [7:0] raw[$]);
      req_type it;
      foreach (raw[i]) begin
         it.rx_byte       = raw[i];
         it.end_of_buffer = (i == raw.size() - 1);
         rx_bytes = {rx_bytes, it};
      end
   endtask

   task automatic add_buffer(input buf_type kind, input int n, input int dle_pct);
      logic [7:0] raw[$];
      logic [7:0] st;
      logic [7:0] len8;
      logic [7:0] acc;
      logic [7:0] d;
      bit         dle_bcc;
      int         k;
      int         cut;
      st   = 8'($urandom);
      len8 = 8'(n);
      if (kind == BUF_NAK || kind == BUF_NOISE) begin
         raw = {raw, (kind == BUF_NAK) ? SymNak : pick_byte()};
         repeat ($urandom_range(0, 7)) raw = {raw, pick_byte()};
      end else begin
         raw = {SymDle, SymStx, st, len8};
         if (len8 == SymDle) raw = {raw, 8'($urandom)};
         acc = st ^ len8;
         // steer the last data byte so that the check byte comes out as dle
         dle_bcc = (kind == BUF_NOT_DOUBLED) || ($urandom_range(0, 5) == 0);
         k = $urandom_range(0, (n > 0) ? n - 1 : 0);
         for (int i = 0; i < n; i++) begin
            if (kind == BUF_BAD_STUFF && i == k) begin
               raw = {raw, SymDle};
               raw = {raw, not_dle()};
            end
            d = roll(dle_pct) ? SymDle : 8'($urandom);
            if (dle_bcc && i == n - 1) d = acc ^ SymDle;
            acc = acc ^ d;
            raw = {raw, d};
            if (d == SymDle) raw = {raw, SymDle};
         end
         if (kind == BUF_BAD_CHECK) begin
            raw = {raw, acc ^ 8'($urandom_range(1, 255))};
         end else begin
            raw = {raw, acc};
            if (acc == SymDle) raw = {raw, (kind == BUF_NOT_DOUBLED) ? not_dle() : SymDle};
         end
         raw = {raw, SymDle};
         raw = {raw, SymEtx};
         case (kind)
            BUF_BAD_H0: begin
               do raw[0] = 8'($urandom);
               while (raw[0] == SymDle || raw[0] == SymNak);
            end
            BUF_BAD_H1: raw[1] = SymStx ^ 8'($urandom_range(1, 255));
            BUF_BAD_END: raw[raw.size() - 1 - $urandom_range(0, 1)] ^= 8'($urandom_range(1, 255));
            BUF_TRAILING: repeat ($urandom_range(1, 4)) raw = {raw, pick_byte()};
            BUF_TRUNC: begin
               cut = $urandom_range(1, raw.size() - 1);
               while (raw.size() > cut) void'(raw.pop_back());
            end
            default: ;
         endcase
      end
      push_buffer(raw);
   endtask

   // ------------------------------------------------------------------
   // stimulus, reset and end of run
   // ------------------------------------------------------------------

   initial begin
      buf_type kind;
      int      n;
      int      r;

      // directed: empty frame with zero status and check byte
      push_buffer({SymDle, SymStx, 8'h00, 8'h00, 8'h00, SymDle, SymEtx});
      // nak answer
      push_buffer({SymNak, 8'hff, 8'h00, 8'h10, 8'h03});
      // a lone byte is too short
      push_buffer({8'hff});
      // one stuffed dle as data, all-ones status
      push_buffer({SymDle, SymStx, 8'hff, 8'h01, SymDle, SymDle, 8'hee, SymDle, SymEtx});

      // one long dle-heavy frame runs the byte counter into saturation
      add_buffer(BUF_GOOD, 255, 60);

      // random buffers of every kind, good ones the most common
      while (rx_bytes.size() < 1000) begin
         r = $urandom_range(0, 99);
         if (r < 35) kind = BUF_GOOD;
         else if (r < 42) kind = BUF_TRAILING;
         else if (r < 48) kind = BUF_NAK;
         else if (r < 53) kind = BUF_BAD_H0;
         else if (r < 57) kind = BUF_BAD_H1;
         else if (r < 64) kind = BUF_BAD_STUFF;
         else if (r < 71) kind = BUF_BAD_CHECK;
         else if (r < 77) kind = BUF_NOT_DOUBLED;
         else if (r < 82) kind = BUF_BAD_END;
         else if (r < 93) kind = BUF_TRUNC;
         else kind = BUF_NOISE;
         if ($urandom_range(0, 39) == 0) n = $urandom_range(30, 60);
         else if ($urandom_range(0, 8) == 0) n = int'(SymDle);
         else n = $urandom_range(0, 10);
         if (n == 0 && (kind == BUF_BAD_STUFF || kind == BUF_NOT_DOUBLED)) n = 1;
         add_buffer(kind, n, 25);
      end

      // the sender drains the block completely at these points
      drain_at = {350, 800};

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (rx_bytes.size() != 0 || req_valid || n_pred != n_done);
      // leave room for any stray result
      repeat (20) @(negedge clock);

      while (frame_results.size() != 0) begin
         $display("%0t: expected item never arrived: %h", $time, frame_results.pop_front());
         n_fail++;
      end
      if (n_fail == 0) begin
         $display("[dle_stx_frame_decoder] OK");
      end else begin
         $display("[dle_stx_frame_decoder] ERROR");
      end
      $finish;
   end

   // ------------------------------------------------------------------
   // request side: predict on acceptance, offer the next item
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         clear_decoder();
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data);
            n_sent <= n_sent + 1;
         end
         // slot free after this edge: either nothing offered or just taken
         if (!req_valid || req_ready) begin
            // drain point: drop req_valid so the counters settle, then
            // wait until every predicted item has been checked
            holding = drain_at.size() != 0 && n_launched == drain_at[0] &&
                      (req_valid || n_pred != n_done);
            if (rx_bytes.size() != 0 && !holding &&
                !roll(idle_mode == IDLE_SENDER ? 79 : idle_mode == IDLE_BOTH ? 16 : 0)) begin
               if (drain_at.size() != 0 && n_launched == drain_at[0]) void'(drain_at.pop_front());
               req_data   <= rx_bytes.pop_front();
               req_valid  <= 1'b1;
               n_launched++;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // result side: check each item against the oldest prediction
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frame_results.size() == 0) begin
               $display("%0t: unexpected item: verdict=%0b data=%02h status=%02h err=%0d",
                        $time, rsp_data.is_verdict, rsp_data.data_byte,
                        rsp_data.reader_status, rsp_data.error_code);
               n_fail++;
            end else begin
               want = frame_results.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: mismatch expected verdict=%0b data=%02h status=%02h err=%0d",
                           $time, want.is_verdict, want.data_byte,
                           want.reader_status, want.error_code);
                  $display("%0t:          actual   verdict=%0b data=%02h status=%02h err=%0d",
                           $time, rsp_data.is_verdict, rsp_data.data_byte,
                           rsp_data.reader_status, rsp_data.error_code);
                  n_fail++;
               end
               n_done <= n_done + 1;
            end
         end
         rsp_ready <= !roll(idle_mode == IDLE_RECEIVER ? 79 : idle_mode == IDLE_BOTH ? 16 : 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("[dle_stx_frame_decoder] ERROR");
         $finish;
      end
   end

endmodule

// ===== sim.f =====
hw/rtl/dsfd_pkg.sv
hw/rtl/dsfd_step.sv
hw/rtl/dle_stx_frame_decoder.sv
hw/rtl/dsfd_checker.sv
test/tb_dle_stx_frame_decoder.sv
